/* rtl/core/single_wire_humidity_sensor_reader_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH

// Same-cycle implication, muted while reset is high
`define SWHSR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("swhsr assertion failed");

// Next-cycle implication, muted while reset is high
`define SWHSR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("swhsr assertion failed");

`endif

/* rtl/core/swhsr_pkg.sv */
package swhsr_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 5;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int BIT_COUNT_W = $clog2(FRAME_BITS + 1);

  // Defaults for the top-level parameters
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // High-pulse count saturates here and ends the bit
  localparam int HIGH_MAX = 255;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_WIDE_W  = 16;
  localparam int CFG_NARROW_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_START_LOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP_LOW_TMO  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP_PHASE_TMO = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_START_TMO = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL          = 3'd6;

  localparam logic [CFG_WIDE_W-1:0]   START_LOW_RST   = 16'd20000;
  localparam logic [CFG_WIDE_W-1:0]   RELEASE_RST     = 16'd30;
  localparam logic [CFG_NARROW_W-1:0] RESP_LOW_RST    = 8'd80;
  localparam logic [CFG_NARROW_W-1:0] RESP_PHASE_RST  = 8'd250;
  localparam logic [CFG_NARROW_W-1:0] BIT_START_RST   = 8'd150;
  localparam logic [CFG_NARROW_W-1:0] ONE_THRESH_RST  = 8'd30;
  localparam logic [CFG_WIDE_W-1:0]   TAIL_RST        = 16'd60;

  typedef struct packed {
    logic [CFG_WIDE_W-1:0]   start_low_ticks;
    logic [CFG_WIDE_W-1:0]   release_ticks;
    logic [CFG_NARROW_W-1:0] response_low_timeout;
    logic [CFG_NARROW_W-1:0] response_phase_timeout;
    logic [CFG_NARROW_W-1:0] bit_start_timeout;
    logic [CFG_NARROW_W-1:0] one_threshold;
    logic [CFG_WIDE_W-1:0]   tail_ticks;
  } swhsr_cfg_t;

  // One tick as it travels through the queue
  typedef struct packed {
    logic start_req;
    logic line_level;
  } swhsr_item_t;

  typedef struct packed {
    logic [4:0] temp_tens;
    logic [3:0] temp_ones;
    logic [3:0] temp_tenths;
    logic [4:0] hum_tens;
    logic [3:0] hum_ones;
  } swhsr_digits_t;

  typedef struct packed {
    logic          drive_low;
    logic          busy_res;
    logic          done_res;
    logic          checksum_ok;
    logic          timeout_seen;
    swhsr_digits_t digits;
  } swhsr_result_t;

  // Byte / 10 by reciprocal: (b * 205) >> 11 is exact for all 8-bit values
  function automatic logic [4:0] div10(input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, b} * 16'd205;
    return p[15:11];
  endfunction

  // Byte % 10 as b - 10 * (b / 10)
  function automatic logic [3:0] mod10(input logic [7:0] b);
    logic [4:0] q;
    logic [7:0] r;
    q = div10(b);
    r = b - {q, 3'b000} - {2'b00, q, 1'b0};
    return r[3:0];
  endfunction

endpackage

/* rtl/core/swhsr_fifo.sv */
module swhsr_fifo #(
  parameter int DEPTH = swhsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_valid,
  output logic                    wr_ready,
  input  swhsr_pkg::swhsr_item_t  wr_item,
  output logic                    rd_valid,
  input  logic                    rd_pop,
  output swhsr_pkg::swhsr_item_t  rd_item
);
  import swhsr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  swhsr_item_t         slots [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !rd_pop) begin
        count <= count + 1'b1;
      end else if (rd_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/swhsr_back.sv */
module swhsr_back #(
  parameter int TIMER_WIDTH = swhsr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  swhsr_pkg::swhsr_item_t   q_item,
  output logic                     q_pop,
  input  swhsr_pkg::swhsr_cfg_t    cfg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swhsr_pkg::swhsr_result_t res
);
  import swhsr_pkg::*;

  localparam int CW = (TIMER_WIDTH > CFG_WIDE_W) ? TIMER_WIDTH : CFG_WIDE_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
  localparam logic [TIMER_WIDTH-1:0] HIGH_LIMIT = TIMER_WIDTH'(HIGH_MAX);

  // Sequencer states
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_START_LOW = 4'd1;
  localparam logic [3:0] PH_RELEASE   = 4'd2;
  localparam logic [3:0] PH_RESP_LOW  = 4'd3;
  localparam logic [3:0] PH_RESP_HIGH = 4'd4;
  localparam logic [3:0] PH_RESP_LOW2 = 4'd5;
  localparam logic [3:0] PH_BIT_START = 4'd6;
  localparam logic [3:0] PH_BIT_HIGH  = 4'd7;
  localparam logic [3:0] PH_TAIL      = 4'd8;

  logic [3:0]             phase, phase_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [BIT_COUNT_W-1:0] bit_count, bit_count_next;
  logic [FRAME_BITS-1:0]  frame, frame_next;
  swhsr_digits_t          digits, digits_next;
  logic                   chk_ok, chk_ok_next;
  logic                   tmo, tmo_next;
  logic                   done;

  logic [TIMER_WIDTH-1:0] tinc;
  logic [TIMER_WIDTH-1:0] hi_inc;
  logic [TIMER_WIDTH-1:0] meas;
  logic [CFG_WIDE_W-1:0]  limit;
  logic                   cur_hit;
  logic                   inc_hit;
  logic                   bit_one;
  logic [BIT_COUNT_W-1:0] bc_inc;
  logic [7:0]             b0, b1, b2, b3, b4;
  logic [7:0]             sum;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // Saturating timer step and limit compares
  assign tinc    = (timer == TMAX) ? timer : timer + 1'b1;
  assign cur_hit = (CW'(timer) >= CW'(limit)) || (timer == TMAX);
  assign inc_hit = (CW'(tinc) >= CW'(limit)) || (tinc == TMAX);

  // High-pulse measurement
  assign hi_inc  = timer + 1'b1;
  assign meas    = q_item.line_level ? hi_inc : timer;
  assign bit_one = CW'(meas) > CW'(cfg.one_threshold);
  assign bc_inc  = bit_count + 1'b1;

  // Frame bytes, byte 0 received first
  assign b0  = frame[39:32];
  assign b1  = frame[31:24];
  assign b2  = frame[23:16];
  assign b3  = frame[15:8];
  assign b4  = frame[7:0];
  assign sum = b0 + b1 + b2 + b3;

  // Limit for the current phase
  always_comb begin
    unique case (phase)
      PH_START_LOW: limit = cfg.start_low_ticks;
      PH_RELEASE:   limit = cfg.release_ticks;
      PH_RESP_LOW:  limit = CFG_WIDE_W'(cfg.response_low_timeout);
      PH_RESP_HIGH,
      PH_RESP_LOW2: limit = CFG_WIDE_W'(cfg.response_phase_timeout);
      PH_BIT_START: limit = CFG_WIDE_W'(cfg.bit_start_timeout);
      PH_TAIL:      limit = cfg.tail_ticks;
      default:      limit = '0;
    endcase
  end

  // One tick of the reading sequence
  always_comb begin
    phase_next     = phase;
    timer_next     = timer;
    bit_count_next = bit_count;
    frame_next     = frame;
    digits_next    = digits;
    chk_ok_next    = chk_ok;
    tmo_next       = tmo;
    done           = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (q_item.start_req) begin
          phase_next     = PH_START_LOW;
          timer_next     = TIMER_WIDTH'(1);
          bit_count_next = '0;
          frame_next     = '0;
          tmo_next       = 1'b0;
        end
      end
      PH_START_LOW, PH_RELEASE, PH_TAIL: begin
        if ((phase == PH_START_LOW && cur_hit) || inc_hit) begin
          timer_next = '0;
          unique case (phase)
            PH_START_LOW: phase_next = PH_RELEASE;
            PH_RELEASE:   phase_next = PH_RESP_LOW;
            default: begin
              // end of reading: checksum, then digits on a match
              phase_next = PH_IDLE;
              done       = 1'b1;
              if (sum == b4) begin
                chk_ok_next             = 1'b1;
                digits_next.temp_tens   = div10(b2);
                digits_next.temp_ones   = mod10(b2);
                digits_next.temp_tenths = mod10(b3);
                digits_next.hum_tens    = div10(b0);
                digits_next.hum_ones    = mod10(b0);
              end else begin
                chk_ok_next = 1'b0;
              end
            end
          endcase
        end else begin
          timer_next = tinc;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_LOW2, PH_BIT_START: begin
        // awaited level ends the wait; a timeout flags and moves on
        if ((q_item.line_level == (phase == PH_RESP_HIGH || phase == PH_BIT_START))
            || inc_hit) begin
          if (!(q_item.line_level == (phase == PH_RESP_HIGH || phase == PH_BIT_START))) begin
            tmo_next = 1'b1;
          end
          timer_next = '0;
          unique case (phase)
            PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
            PH_RESP_HIGH: phase_next = PH_RESP_LOW2;
            PH_RESP_LOW2: phase_next = PH_BIT_START;
            default:      phase_next = PH_BIT_HIGH;
          endcase
        end else begin
          timer_next = tinc;
        end
      end
      PH_BIT_HIGH: begin
        if (!q_item.line_level || hi_inc >= HIGH_LIMIT) begin
          frame_next     = {frame[FRAME_BITS-2:0], bit_one};
          bit_count_next = bc_inc;
          timer_next     = '0;
          phase_next     = (bc_inc >= BIT_COUNT_W'(FRAME_BITS)) ? PH_TAIL : PH_BIT_START;
        end else begin
          timer_next = hi_inc;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        timer_next = '0;
      end
    endcase
  end

  // Sequencer state, advanced once per popped tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      timer     <= '0;
      bit_count <= '0;
      frame     <= '0;
      digits    <= '0;
      chk_ok    <= 1'b0;
      tmo       <= 1'b0;
    end else if (q_pop) begin
      phase     <= phase_next;
      timer     <= timer_next;
      bit_count <= bit_count_next;
      frame     <= frame_next;
      digits    <= digits_next;
      chk_ok    <= chk_ok_next;
      tmo       <= tmo_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.drive_low    <= (phase_next == PH_START_LOW);
      res.busy_res     <= (phase_next != PH_IDLE);
      res.done_res     <= done;
      res.checksum_ok  <= chk_ok_next;
      res.timeout_seen <= tmo_next;
      res.digits       <= digits_next;
    end
  end

endmodule

/* rtl/core/single_wire_humidity_sensor_reader.sv */
// Single-wire temperature/humidity sensor reader.
// Input channel (in_valid/in_ready): one transfer per timing tick, carrying
// start_req and the sampled line_level. Output channel (out_valid/out_ready):
// exactly one result transfer per input transfer, in order, giving the wire
// drive, busy/done status, checksum and timeout flags and the decimal digits.
// Config channel (cfg_valid/cfg_ready): cfg_index selects one of seven
// timing registers, cfg_data is written; cfg_ready is always high. Write
// only while no tick is in flight.
// Throughput: one tick per cycle while out_ready is high; the sequencer
// advances one tick per cycle unless the receiver stalls, and a queue of
// QUEUE_DEPTH entries (two by default) in front of it plus the output
// register keep both channels moving independently.
// Reset: config registers take their defaults, the sequencer goes idle,
// digits and flags clear, queue and output register empty.
// Receiver stall: the result holds; the sequencer stops, the queue fills and
// in_ready drops once all QUEUE_DEPTH entries are taken.
module single_wire_humidity_sensor_reader #(
  parameter int TIMER_WIDTH = swhsr_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = swhsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  start_req,
  input  logic                                  line_level,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  drive_low,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic                                  checksum_ok,
  output logic                                  timeout_seen,
  output logic [4:0]                            temp_tens,
  output logic [3:0]                            temp_ones,
  output logic [3:0]                            temp_tenths,
  output logic [4:0]                            hum_tens,
  output logic [3:0]                            hum_ones,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swhsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [swhsr_pkg::CFG_WIDE_W-1:0]      cfg_data
);
  import swhsr_pkg::*;

  swhsr_cfg_t    cfg;
  swhsr_item_t   in_item;
  swhsr_item_t   q_item;
  logic          q_valid;
  logic          q_pop;
  swhsr_result_t res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks        <= START_LOW_RST;
      cfg.release_ticks          <= RELEASE_RST;
      cfg.response_low_timeout   <= RESP_LOW_RST;
      cfg.response_phase_timeout <= RESP_PHASE_RST;
      cfg.bit_start_timeout      <= BIT_START_RST;
      cfg.one_threshold          <= ONE_THRESH_RST;
      cfg.tail_ticks             <= TAIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_LOW:      cfg.start_low_ticks        <= cfg_data;
        REG_RELEASE:        cfg.release_ticks          <= cfg_data;
        REG_RESP_LOW_TMO:   cfg.response_low_timeout   <= cfg_data[CFG_NARROW_W-1:0];
        REG_RESP_PHASE_TMO: cfg.response_phase_timeout <= cfg_data[CFG_NARROW_W-1:0];
        REG_BIT_START_TMO:  cfg.bit_start_timeout      <= cfg_data[CFG_NARROW_W-1:0];
        REG_ONE_THRESHOLD:  cfg.one_threshold          <= cfg_data[CFG_NARROW_W-1:0];
        REG_TAIL:           cfg.tail_ticks             <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.start_req  = start_req;
  assign in_item.line_level = line_level;

  // Front: tick queue
  swhsr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (in_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  // Back: reading sequencer and output register
  swhsr_back #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign drive_low    = res.drive_low;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign checksum_ok  = res.checksum_ok;
  assign timeout_seen = res.timeout_seen;
  assign temp_tens    = res.digits.temp_tens;
  assign temp_ones    = res.digits.temp_ones;
  assign temp_tenths  = res.digits.temp_tenths;
  assign hum_tens     = res.digits.hum_tens;
  assign hum_ones     = res.digits.hum_ones;

endmodule

/* rtl/core/swhsr_checker.sv */
`include "single_wire_humidity_sensor_reader_assert.svh"

module swhsr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [4:0] temp_tens,
  input logic [3:0] temp_ones,
  input logic [3:0] temp_tenths,
  input logic [4:0] hum_tens,
  input logic [3:0] hum_ones
);

  // A finished reading leaves the block idle with the wire released
  `SWHSR_ASSERT_IMP(a_done_idle, clk, rst, out_valid && done_res, !busy_res && !drive_low)

  // Driving the wire only happens inside a reading
  `SWHSR_ASSERT_IMP(a_drive_busy, clk, rst, out_valid && drive_low, busy_res)

  // Two finished readings never come from consecutive ticks
  `SWHSR_ASSERT_NXT(a_done_single, clk, rst, out_valid && out_ready && done_res,
                    !(out_valid && done_res))

  // Digits stay decimal
  `SWHSR_ASSERT_IMP(a_digit_range, clk, rst, out_valid,
                    temp_ones <= 4'd9 && temp_tenths <= 4'd9 && hum_ones <= 4'd9 &&
                    temp_tens <= 5'd25 && hum_tens <= 5'd25)

  // A stalled result holds
  `SWHSR_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(done_res) && $stable(busy_res))

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .drive_low   (drive_low),
  .busy_res    (busy_res),
  .done_res    (done_res),
  .temp_tens   (temp_tens),
  .temp_ones   (temp_ones),
  .temp_tenths (temp_tenths),
  .hum_tens    (hum_tens),
  .hum_ones    (hum_ones)
);

/* dv/tb_single_wire_humidity_sensor_reader.sv */
`timescale 1ns / 100ps

module tb_single_wire_humidity_sensor_reader;
  import swhsr_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned NOIDLE_FROM  = 500;
  localparam int unsigned NOIDLE_TO    = 800;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_LEN     = 100;
  localparam int unsigned IDLE_PCT     = 24;
  localparam logic [CFG_INDEX_W-1:0]     REG_UNUSED = 3'd7;
  localparam logic [TIMER_WIDTH_DEF-1:0] TMR_TOP    = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_START_LOW, S_RELEASE, S_RESP_LOW, S_RESP_HIGH, S_RESP_LOW2,
    S_BIT_START, S_BIT_HIGH, S_TAIL
  } seq_phase_e;

  typedef enum int {RD_CLEAN, RD_BAD_SUM, RD_STUCK, RD_NOISE} reading_kind_e;

  // Tracks the sequencer tick by tick and holds the status words still owed
  class reading_tracker;
    swhsr_cfg_t                 regs;
    seq_phase_e                 ph;
    logic [TIMER_WIDTH_DEF-1:0] timer;
    logic [BIT_COUNT_W-1:0]     nbits;
    logic [FRAME_BITS-1:0]      frame;
    swhsr_digits_t              digits;
    logic                       sum_ok;
    logic                       tmo;
    swhsr_result_t              due_status[$];
    int unsigned                errors;
    int unsigned                ticks;

    function new();
      regs = '{START_LOW_RST, RELEASE_RST, RESP_LOW_RST, RESP_PHASE_RST,
               BIT_START_RST, ONE_THRESH_RST, TAIL_RST};
      ph = S_IDLE;
      timer = '0;
      nbits = '0;
      frame = '0;
      digits = '0;
      sum_ok = 1'b0;
      tmo = 1'b0;
      errors = 0;
      ticks = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_WIDE_W-1:0] data);
      case (idx)
        REG_START_LOW:      regs.start_low_ticks = data;
        REG_RELEASE:        regs.release_ticks = data;
        REG_RESP_LOW_TMO:   regs.response_low_timeout = data[7:0];
        REG_RESP_PHASE_TMO: regs.response_phase_timeout = data[7:0];
        REG_BIT_START_TMO:  regs.bit_start_timeout = data[7:0];
        REG_ONE_THRESHOLD:  regs.one_threshold = data[7:0];
        REG_TAIL:           regs.tail_ticks = data;
        default: ;
      endcase
    endfunction

    function void bump();
      if (timer != TMR_TOP) timer++;
    endfunction

    function bit delay_over(logic [15:0] n);
      bump();
      return timer >= n || timer == TMR_TOP;
    endfunction

    // wait phase: the awaited level ends it, otherwise it may run out
    function bit wait_over(logic hit, logic [15:0] lim);
      if (hit) return 1'b1;
      bump();
      if (timer >= lim || timer == TMR_TOP) begin
        tmo = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void go(seq_phase_e p);
      ph = p;
      timer = '0;
    endfunction

    function void close_bit();
      logic one;
      one = timer > regs.one_threshold;
      frame = {frame[FRAME_BITS-2:0], one};
      nbits++;
      if (nbits >= FRAME_BITS) go(S_TAIL);
      else go(S_BIT_START);
    endfunction

    // checksum over bytes 0..3; digits move only on a match
    function void close_frame();
      logic [7:0] b0, b1, b2, b3, b4, total;
      b0 = frame[39:32];
      b1 = frame[31:24];
      b2 = frame[23:16];
      b3 = frame[15:8];
      b4 = frame[7:0];
      total = b0 + b1 + b2 + b3;
      if (total == b4) begin
        sum_ok = 1'b1;
        digits.temp_tens   = 5'(b2 / 10);
        digits.temp_ones   = 4'(b2 % 10);
        digits.temp_tenths = 4'(b3 % 10);
        digits.hum_tens    = 5'(b0 / 10);
        digits.hum_ones    = 4'(b0 % 10);
      end else begin
        sum_ok = 1'b0;
      end
      go(S_IDLE);
    endfunction

    // one accepted tick: advance the sequence and queue the status it yields
    function void take_tick(swhsr_item_t it);
      logic          fin;
      swhsr_result_t r;
      fin = 1'b0;
      ticks++;
      case (ph)
        S_IDLE: begin
          if (it.start_req) begin
            go(S_START_LOW);
            nbits = '0;
            frame = '0;
            tmo = 1'b0;
            timer = TIMER_WIDTH_DEF'(1);
          end
        end
        S_START_LOW: begin
          if (timer >= regs.start_low_ticks || timer == TMR_TOP) go(S_RELEASE);
          else if (delay_over(regs.start_low_ticks)) go(S_RELEASE);
        end
        S_RELEASE: if (delay_over(regs.release_ticks)) go(S_RESP_LOW);
        S_RESP_LOW: begin
          if (wait_over(!it.line_level, regs.response_low_timeout)) go(S_RESP_HIGH);
        end
        S_RESP_HIGH: begin
          if (wait_over(it.line_level, regs.response_phase_timeout)) go(S_RESP_LOW2);
        end
        S_RESP_LOW2: begin
          if (wait_over(!it.line_level, regs.response_phase_timeout)) go(S_BIT_START);
        end
        S_BIT_START: begin
          if (wait_over(it.line_level, regs.bit_start_timeout)) go(S_BIT_HIGH);
        end
        S_BIT_HIGH: begin
          if (it.line_level) begin
            timer++;
            if (timer >= HIGH_MAX) close_bit();
          end else begin
            close_bit();
          end
        end
        S_TAIL: begin
          if (delay_over(regs.tail_ticks)) begin
            close_frame();
            fin = 1'b1;
          end
        end
        default: go(S_IDLE);
      endcase
      r.drive_low    = (ph == S_START_LOW);
      r.busy_res     = (ph != S_IDLE);
      r.done_res     = fin;
      r.checksum_ok  = sum_ok;
      r.timeout_seen = tmo;
      r.digits       = digits;
      due_status.push_back(r);
    endfunction

    function void field_check(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_status(swhsr_result_t got);
      swhsr_result_t want;
      if (due_status.size() == 0) begin
        $error("status transfer with nothing outstanding");
        errors++;
        return;
      end
      want = due_status.pop_front();
      field_check("drive_low", want.drive_low, got.drive_low);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("done_res", want.done_res, got.done_res);
      field_check("checksum_ok", want.checksum_ok, got.checksum_ok);
      field_check("timeout_seen", want.timeout_seen, got.timeout_seen);
      field_check("temp_tens", want.digits.temp_tens, got.digits.temp_tens);
      field_check("temp_ones", want.digits.temp_ones, got.digits.temp_ones);
      field_check("temp_tenths", want.digits.temp_tenths, got.digits.temp_tenths);
      field_check("hum_tens", want.digits.hum_tens, got.digits.hum_tens);
      field_check("hum_ones", want.digits.hum_ones, got.digits.hum_ones);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   start_req = 1'b0;
  logic                   line_level = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   drive_low, busy_res, done_res, checksum_ok, timeout_seen;
  logic [4:0]             temp_tens, hum_tens;
  logic [3:0]             temp_ones, temp_tenths, hum_ones;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_WIDE_W-1:0]  cfg_data = '0;

  int unsigned    cyc = 0;
  reading_tracker sb = new();

  // sensor emulation for the reading in progress
  logic [FRAME_BITS-1:0] rd_frame;
  int                    hi_len[FRAME_BITS];
  reading_kind_e         rd_kind = RD_NOISE;
  seq_phase_e            stuck_ph = S_IDLE;
  int                    stuck_bit = 0;
  logic                  want_start = 1'b0;

  single_wire_humidity_sensor_reader uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_req    (start_req),
    .line_level   (line_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_low    (drive_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .checksum_ok  (checksum_ok),
    .timeout_seen (timeout_seen),
    .temp_tens    (temp_tens),
    .temp_ones    (temp_ones),
    .temp_tenths  (temp_tenths),
    .hum_tens     (hum_tens),
    .hum_ones     (hum_ones),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("[single_wire_humidity_sensor_reader] ERROR");
      $finish;
    end
  end

  // transfers seen at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_tick({start_req, line_level});
      if (out_valid && out_ready)
        sb.match_status({drive_low, busy_res, done_res, checksum_ok, timeout_seen,
                         temp_tens, temp_ones, temp_tenths, hum_tens, hum_ones});
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  function automatic bit idle_draw();
    if (cyc >= NOIDLE_FROM && cyc < NOIDLE_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // level for a response wait: always wrong when stuck, else wrong only while it cannot run out
  function automatic logic wait_level(logic good, int lim, bit stuck);
    if (stuck) return !good;
    if (sb.timer + 1 < lim && $urandom_range(0, 1) == 1) return !good;
    return good;
  endfunction

  // next tick as the sensor would answer the current phase
  function automatic swhsr_item_t sensor_tick();
    swhsr_item_t it;
    it.line_level = $urandom_range(0, 1);
    it.start_req = (sb.ph == S_IDLE) ? want_start : ($urandom_range(0, 99) < 30);
    if (rd_kind != RD_NOISE) begin
      case (sb.ph)
        S_RESP_LOW:
          it.line_level = wait_level(1'b0, sb.regs.response_low_timeout,
                                     stuck_ph == S_RESP_LOW);
        S_RESP_HIGH:
          it.line_level = wait_level(1'b1, sb.regs.response_phase_timeout,
                                     stuck_ph == S_RESP_HIGH);
        S_RESP_LOW2:
          it.line_level = wait_level(1'b0, sb.regs.response_phase_timeout,
                                     stuck_ph == S_RESP_LOW2);
        S_BIT_START:
          it.line_level = wait_level(1'b1, sb.regs.bit_start_timeout,
                                     stuck_ph == S_BIT_START && sb.nbits == stuck_bit);
        S_BIT_HIGH: it.line_level = (sb.timer < hi_len[sb.nbits]);
        default: ;
      endcase
    end
    return it;
  endfunction

  // one input transfer; starts and ends at a falling edge
  task automatic push_tick();
    swhsr_item_t it;
    while (idle_draw()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it = sensor_tick();
    start_req  <= it.start_req;
    line_level <= it.line_level;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [CFG_WIDE_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // narrow registers get junk in the unused upper byte
  task automatic set_timing(logic [15:0] s_low, logic [15:0] rel, logic [7:0] rlow,
                            logic [7:0] rphase, logic [7:0] bstart, logic [7:0] thr,
                            logic [15:0] tail);
    cfg_put(REG_START_LOW, s_low);
    cfg_put(REG_RELEASE, rel);
    cfg_put(REG_RESP_LOW_TMO, {8'($urandom), rlow});
    cfg_put(REG_RESP_PHASE_TMO, {8'($urandom), rphase});
    cfg_put(REG_BIT_START_TMO, {8'($urandom), bstart});
    cfg_put(REG_ONE_THRESHOLD, {8'($urandom), thr});
    cfg_put(REG_TAIL, tail);
    cfg_put(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering ticks and let every owed status word arrive
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.due_status.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // one full reading: random frame, pulse widths chosen around the threshold
  task automatic run_reading(reading_kind_e kind);
    logic [7:0] b[5];
    int         thr, near;
    rd_kind = kind;
    stuck_ph = S_IDLE;
    stuck_bit = 0;
    for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
    b[4] = b[0] + b[1] + b[2] + b[3];
    if (kind == RD_BAD_SUM) b[4] = b[4] + 8'($urandom_range(1, 255));
    if (kind == RD_STUCK) begin
      case ($urandom_range(0, 3))
        0: stuck_ph = S_RESP_LOW;
        1: stuck_ph = S_RESP_HIGH;
        2: stuck_ph = S_RESP_LOW2;
        default: stuck_ph = S_BIT_START;
      endcase
      stuck_bit = $urandom_range(0, FRAME_BITS - 1);
    end
    rd_frame = {b[0], b[1], b[2], b[3], b[4]};
    thr = sb.regs.one_threshold;
    near = (thr > 2) ? 2 : thr;
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (rd_frame[FRAME_BITS-1-i])
        hi_len[i] = ($urandom_range(0, 39) == 0) ? HIGH_MAX + $urandom_range(0, 9)
                                                 : thr + 1 + $urandom_range(0, 2);
      else
        hi_len[i] = ($urandom_range(0, 1) == 1) ? $urandom_range(0, near)
                                                : thr - $urandom_range(0, near);
    end
    want_start = 1'b0;
    repeat ($urandom_range(0, 3)) push_tick();
    want_start = 1'b1;
    push_tick();
    want_start = 1'b0;
    while (sb.ph != S_IDLE) push_tick();
  endtask

  function automatic reading_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return RD_CLEAN;
    if (r < 75) return RD_BAD_SUM;
    if (r < 88) return RD_STUCK;
    return RD_NOISE;
  endfunction

  function automatic logic [7:0] pick_tmo();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom);
  endfunction

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !idle_draw();
      end
    end
  end

  // stimulus
  initial begin
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle ticks on reset timing
    repeat (4) push_tick();

    // zero everywhere: delays act as one, waits run out at once unless met
    quiesce();
    set_timing(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    run_reading(RD_CLEAN);
    run_reading(RD_BAD_SUM);
    run_reading(RD_STUCK);

    // random timing, mostly short
    for (k = 0; k < 1 || sb.ticks < 800; k++) begin
      quiesce();
      set_timing($urandom_range(0, 6), $urandom_range(0, 6), pick_tmo(), pick_tmo(),
                 pick_tmo(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 4),
                 $urandom_range(0, 6));
      run_reading(pick_kind());
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("[single_wire_humidity_sensor_reader] OK");
    end else begin
      $display("[single_wire_humidity_sensor_reader] ERROR");
    end
    $finish;
  end

endmodule
